// ===== src/bdlp_pkg.sv =====
package bdlp_pkg;

	// Register widths
	localparam int unsigned DebounceW = 7;
	localparam int unsigned CountW    = 8;
	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned CfgDataW  = 8;

	// Register reset values
	localparam logic [DebounceW-1:0] DEBOUNCE_RESET  = 7'd80;
	localparam logic [CountW-1:0]    THRESHOLD_RESET = 8'd100;
	localparam logic [CountW-1:0]    RELEASED_RESET  = 8'hFF;

	// Register indexes on the configuration port
	typedef enum logic [CfgIndexW-1:0] {
		CFG_DEBOUNCE  = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_RELEASED  = 2'd2
	} cfg_idx_t;

	// State of one hold tracker after a tick
	typedef struct packed {
		logic              long_flag;
		logic [CountW-1:0] count;
	} hold_stat_t;

endpackage

// ===== src/bdlp_edge.sv =====
module bdlp_edge import bdlp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 level,
	input  logic [DebounceW-1:0] debounce,
	output logic                 hit
);

	logic [DebounceW-1:0] timer_q;
	logic                 last_q;

	// Falling edge counts only while the lockout timer is idle
	assign hit = (timer_q == '0) && last_q && !level;

	// Lockout timer and stored level; level is frozen during lockout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			last_q  <= 1'b1;
		end else if (en) begin
			if (timer_q == '0) begin
				if (hit) begin
					timer_q <= debounce;
				end
				last_q <= level;
			end else begin
				timer_q <= timer_q - DebounceW'(1);
			end
		end
	end

endmodule

// ===== src/bdlp_hold.sv =====
module bdlp_hold import bdlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              level,
	input  logic              press,
	input  logic              clr,
	input  logic [CountW-1:0] threshold,
	input  logic [CountW-1:0] released_code,
	output hold_stat_t        stat
);

	logic              tracking_q;
	logic              phase_q;
	logic              long_q;
	logic [CountW-1:0] count_q;

	logic              trk_n;
	logic              phase_n;
	logic              long_n;
	logic [CountW-1:0] cnt_n;
	logic [CountW-1:0] cnt_inc;

	// Next state for one tick: clear first, then press, then sampling every other tick
	always_comb begin
		cnt_n   = clr ? '0 : count_q;
		trk_n   = tracking_q | press;
		phase_n = phase_q;
		long_n  = long_q;
		cnt_inc = cnt_n + CountW'(1);
		if (trk_n) begin
			if (!phase_q) begin
				if (!level) begin
					cnt_n   = cnt_inc;
					phase_n = 1'b1;
					if (cnt_inc == threshold) begin
						long_n = 1'b1;
					end
				end else begin
					if (long_q) begin
						long_n = 1'b0;
						cnt_n  = '0;
					end else begin
						cnt_n = released_code;
					end
					phase_n = 1'b0;
					trk_n   = 1'b0;
				end
			end else begin
				phase_n = 1'b0;
			end
		end
	end

	assign stat.long_flag = long_n;
	assign stat.count     = cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b0;
			phase_q    <= 1'b0;
			long_q     <= 1'b0;
			count_q    <= '0;
		end else if (en) begin
			tracking_q <= trk_n;
			phase_q    <= phase_n;
			long_q     <= long_n;
			count_q    <= cnt_n;
		end
	end

endmodule

// ===== src/button_debounce_long_press_core.sv =====
// Each accepted word passes the input register, the tick logic and the output register.
// Throughput: one word per cycle while no stall holds; the tick logic is a single pass.
// The input register takes one new word while a stalled result waits in the output register.
// Reset (arst_n low, asynchronous): both registers empty, counters and flags zero,
// stored levels released, lockout timers zero, registers back to 80 / 100 / 255.
module button_debounce_long_press_core import bdlp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_wr_en,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 start_level,
	input  logic                 up_level,
	input  logic                 down_level,
	input  logic                 clear_press_count,
	input  logic                 clear_up_count,
	input  logic                 clear_down_count,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CountW-1:0]    press_count,
	output logic [CountW-1:0]    up_count,
	output logic [CountW-1:0]    down_count,
	output logic                 up_long,
	output logic                 down_long
);

	// Configuration registers
	logic [DebounceW-1:0] debounce_q;
	logic [CountW-1:0]    threshold_q;
	logic [CountW-1:0]    released_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RESET;
			threshold_q <= THRESHOLD_RESET;
			released_q  <= RELEASED_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEBOUNCE:  debounce_q  <= cfg_data[DebounceW-1:0];
				CFG_THRESHOLD: threshold_q <= cfg_data;
				CFG_RELEASED:  released_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	logic valid_s1;
	logic start_s1, up_s1, down_s1;
	logic clr_press_s1, clr_up_s1, clr_down_s1;
	logic advance;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			start_s1     <= start_level;
			up_s1        <= up_level;
			down_s1      <= down_level;
			clr_press_s1 <= clear_press_count;
			clr_up_s1    <= clear_up_count;
			clr_down_s1  <= clear_down_count;
		end
	end

	// Edge detectors with lockout, one per button
	logic start_hit, up_hit, down_hit;

	bdlp_edge u_edge_start (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.level    (start_s1),
		.debounce (debounce_q),
		.hit      (start_hit)
	);

	bdlp_edge u_edge_up (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.level    (up_s1),
		.debounce (debounce_q),
		.hit      (up_hit)
	);

	bdlp_edge u_edge_down (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.level    (down_s1),
		.debounce (debounce_q),
		.hit      (down_hit)
	);

	// Start press counter
	logic [CountW-1:0] presses_q;
	logic [CountW-1:0] presses_n;

	always_comb begin
		presses_n = clr_press_s1 ? '0 : presses_q;
		if (start_hit) begin
			presses_n = presses_n + CountW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presses_q <= '0;
		end else if (advance) begin
			presses_q <= presses_n;
		end
	end

	// Hold trackers for up and down
	hold_stat_t up_stat, down_stat;

	bdlp_hold u_hold_up (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.level         (up_s1),
		.press         (up_hit),
		.clr           (clr_up_s1),
		.threshold     (threshold_q),
		.released_code (released_q),
		.stat          (up_stat)
	);

	bdlp_hold u_hold_down (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.level         (down_s1),
		.press         (down_hit),
		.clr           (clr_down_s1),
		.threshold     (threshold_q),
		.released_code (released_q),
		.stat          (down_stat)
	);

	// Output register
	logic              out_valid_q;
	logic [CountW-1:0] press_count_q, up_count_q, down_count_q;
	logic              up_long_q, down_long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			press_count_q <= '0;
			up_count_q    <= '0;
			down_count_q  <= '0;
			up_long_q     <= 1'b0;
			down_long_q   <= 1'b0;
		end else if (advance) begin
			out_valid_q   <= 1'b1;
			press_count_q <= presses_n;
			up_count_q    <= up_stat.count;
			down_count_q  <= down_stat.count;
			up_long_q     <= up_stat.long_flag;
			down_long_q   <= down_stat.long_flag;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign press_count = press_count_q;
	assign up_count    = up_count_q;
	assign down_count  = down_count_q;
	assign up_long     = up_long_q;
	assign down_long   = down_long_q;

endmodule

// ===== src/bdlp_checker.sv =====
module bdlp_checker import bdlp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [CountW-1:0]    press_count,
	input logic [CountW-1:0]    up_count,
	input logic [CountW-1:0]    down_count,
	input logic                 up_long,
	input logic                 down_long
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(press_count)
			&& $stable(up_count) && $stable(down_count))
		else $error("stalled result word changed");

	// Press count moves by one press, is cleared, or is cleared and then pressed
	a_press_step: assert property (@(posedge clk) disable iff (!arst_n)
		press_count != $past(press_count) |->
			press_count == CountW'($past(press_count) + CountW'(1)) || press_count == '0
			|| press_count == CountW'(1))
		else $error("press count jumped");

	// Release after a long press clears the up count
	a_up_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(up_long) |-> up_count == '0)
		else $error("up long flag dropped with nonzero count");

	// Release after a long press clears the down count
	a_down_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(down_long) |-> down_count == '0)
		else $error("down long flag dropped with nonzero count");

endmodule

bind button_debounce_long_press_core bdlp_checker u_bdlp_checker (.*);

// ===== test/tb_button_debounce_long_press_core.sv =====
`timescale 1ns / 1ps

module tb_button_debounce_long_press_core;
	import bdlp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 60;

	// one scan tick as offered to the block
	typedef struct packed {
		logic start_lv;
		logic up_lv;
		logic down_lv;
		logic clr_press;
		logic clr_up;
		logic clr_down;
	} scan_word_t;

	// button state after a tick
	typedef struct packed {
		logic [CountW-1:0] press;
		hold_stat_t        up;
		hold_stat_t        down;
	} button_stat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_wr_en = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = CFG_DEBOUNCE;
	logic [CfgDataW-1:0]  cfg_data  = '0;

	logic in_valid          = 1'b0;
	logic start_level       = 1'b1;
	logic up_level          = 1'b1;
	logic down_level        = 1'b1;
	logic clear_press_count = 1'b0;
	logic clear_up_count    = 1'b0;
	logic clear_down_count  = 1'b0;
	logic in_stall;

	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CountW-1:0] press_count;
	logic [CountW-1:0] up_count;
	logic [CountW-1:0] down_count;
	logic              up_long;
	logic              down_long;

	button_debounce_long_press_core DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.start_level      (start_level),
		.up_level         (up_level),
		.down_level       (down_level),
		.clear_press_count(clear_press_count),
		.clear_up_count   (clear_up_count),
		.clear_down_count (clear_down_count),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.press_count      (press_count),
		.up_count         (up_count),
		.down_count       (down_count),
		.up_long          (up_long),
		.down_long        (down_long)
	);

	always #5 clk = ~clk;

	scan_word_t   pending_words[$];
	button_stat_t expected_stats[$];

	// predictor state and register copies
	logic [DebounceW-1:0] cfg_debounce  = DEBOUNCE_RESET;
	logic [CountW-1:0]    cfg_threshold = THRESHOLD_RESET;
	logic [CountW-1:0]    cfg_released  = RELEASED_RESET;
	logic [2:0]           seen_level    = 3'b111;
	logic [DebounceW-1:0] lock_left [3] = '{default: '0};
	logic                 tracking  [2] = '{default: 1'b0};
	logic                 odd_tick  [2] = '{default: 1'b0};
	logic                 long_flag [2] = '{default: 1'b0};
	logic [CountW-1:0]    hold_cnt  [2] = '{default: '0};
	logic [CountW-1:0]    press_cnt     = '0;

	// stimulus generator state per button: level and ticks left in this run
	logic pin_level [3] = '{default: 1'b1};
	int   run_left  [3] = '{default: 0};

	int   error_count    = 0;
	int   results_seen   = 0;
	int   long_words     = 0;
	int   settings_run   = 1;
	int   cycle_count    = 0;
	logic quiet_tail     = 1'b0;
	logic long_hold_done = 1'b0;
	int   hold_left      = 0;
	int   stall_left     = 0;
	int   send_gap       = 0;

	// accepted falling edge with lockout
	function automatic logic debounce_edge(int idx, logic level);
		logic hit;
		hit = 1'b0;
		if (lock_left[idx] == '0) begin
			if (seen_level[idx] && !level) begin
				hit = 1'b1;
				lock_left[idx] = cfg_debounce;
			end
			seen_level[idx] = level;
		end else begin
			lock_left[idx] = lock_left[idx] - 1'b1;
		end
		return hit;
	endfunction

	// hold tracking, sampled every second tick
	function automatic void hold_step(int b, logic level);
		if (!tracking[b])
			return;
		if (!odd_tick[b]) begin
			if (!level) begin
				hold_cnt[b] = hold_cnt[b] + 1'b1;
				if (hold_cnt[b] == cfg_threshold)
					long_flag[b] = 1'b1;
				odd_tick[b] = 1'b1;
			end else begin
				if (long_flag[b]) begin
					long_flag[b] = 1'b0;
					hold_cnt[b] = '0;
				end else begin
					hold_cnt[b] = cfg_released;
				end
				tracking[b] = 1'b0;
			end
		end else begin
			odd_tick[b] = 1'b0;
		end
	endfunction

	function automatic button_stat_t scan_tick(scan_word_t w);
		button_stat_t s;
		if (w.clr_press)
			press_cnt = '0;
		if (w.clr_up)
			hold_cnt[0] = '0;
		if (w.clr_down)
			hold_cnt[1] = '0;
		if (debounce_edge(0, w.start_lv))
			press_cnt = press_cnt + 1'b1;
		if (debounce_edge(1, w.up_lv))
			tracking[0] = 1'b1;
		hold_step(0, w.up_lv);
		if (debounce_edge(2, w.down_lv))
			tracking[1] = 1'b1;
		hold_step(1, w.down_lv);
		s.press          = press_cnt;
		s.up.count       = hold_cnt[0];
		s.up.long_flag   = long_flag[0];
		s.down.count     = hold_cnt[1];
		s.down.long_flag = long_flag[1];
		return s;
	endfunction

	// driver: one word per handshake, random gaps outside the quiet tail
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_stats.push_back(scan_tick({start_level, up_level, down_level,
					clear_press_count, clear_up_count, clear_down_count}));
			if (in_valid && in_stall) begin
				// hold the word
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0 && !quiet_tail
				&& $urandom_range(0, 11) == 0) begin
				send_gap = $urandom_range(1, 8) - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				scan_word_t w;
				w = pending_words.pop_front();
				start_level       <= w.start_lv;
				up_level          <= w.up_lv;
				down_level        <= w.down_lv;
				clear_press_count <= w.clr_press;
				clear_up_count    <= w.clr_up;
				clear_down_count  <= w.clr_down;
				in_valid          <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall: random bursts outside the quiet tail, plus one long hold-off after 400 results
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!long_hold_done && results_seen >= 400) begin
			long_hold_done <= 1'b1;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 8) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: compare each taken word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (up_long || down_long)
				long_words++;
			if (expected_stats.size() == 0) begin
				$error("result word with nothing expected");
				error_count++;
			end else begin
				button_stat_t e;
				e = expected_stats.pop_front();
				if (press_count !== e.press) begin
					$error("press_count: expected %0d, got %0d", e.press, press_count);
					error_count++;
				end
				if (up_count !== e.up.count) begin
					$error("up_count: expected %0d, got %0d", e.up.count, up_count);
					error_count++;
				end
				if (down_count !== e.down.count) begin
					$error("down_count: expected %0d, got %0d", e.down.count, down_count);
					error_count++;
				end
				if (up_long !== e.up.long_flag) begin
					$error("up_long: expected %0b, got %0b", e.up.long_flag, up_long);
					error_count++;
				end
				if (down_long !== e.down.long_flag) begin
					$error("down_long: expected %0b, got %0b", e.down.long_flag, down_long);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic add_word(logic s, logic u, logic d, logic cp, logic cu, logic cd);
		pending_words.push_back({s, u, d, cp, cu, cd});
	endtask

	// wait until every word is sent and answered, then let the pipeline settle;
	// checked between edges so the driver and monitor have already updated
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_stats.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_DEBOUNCE:  cfg_debounce  = val[DebounceW-1:0];
			CFG_THRESHOLD: cfg_threshold = val;
			CFG_RELEASED:  cfg_released  = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_regs(logic [7:0] deb, logic [7:0] thr, logic [7:0] rel);
		write_reg(CFG_DEBOUNCE, deb);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_RELEASED, rel);
		settings_run++;
	endtask

	// press/release runs per button, some long enough to reach the threshold,
	// with occasional contact bounce and count clears
	task automatic queue_scan_ticks(int n);
		int span;
		int rest;
		logic [2:0] lv;
		span = (cfg_threshold == 0) ? 256 : int'(cfg_threshold);
		rest = int'(cfg_debounce) + 6;
		for (int k = 0; k < n; k++) begin
			for (int b = 0; b < 3; b++) begin
				if (run_left[b] == 0) begin
					pin_level[b] = ~pin_level[b];
					if (!pin_level[b]) begin
						case ($urandom_range(0, 4))
							0, 1: run_left[b] = $urandom_range(1, 4);
							2, 3: run_left[b] = $urandom_range(2 * span, 2 * span + 8);
							default: run_left[b] = $urandom_range(1, 2 * span + 8);
						endcase
					end else begin
						run_left[b] = $urandom_range(1, rest);
					end
				end
				run_left[b]--;
				lv[b] = pin_level[b];
				if ($urandom_range(0, 19) == 0)
					lv[b] = ~lv[b];
			end
			add_word(lv[0], lv[1], lv[2], $urandom_range(0, 23) == 0,
				$urandom_range(0, 23) == 0, $urandom_range(0, 23) == 0);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: all three pressed at once, then a short release
		add_word(1, 1, 1, 0, 0, 0);
		add_word(0, 0, 0, 0, 0, 0);
		add_word(1, 1, 1, 0, 0, 0);
		add_word(1, 1, 1, 0, 0, 0);
		add_word(1, 1, 1, 1, 1, 1);
		wait_drained();

		// no lockout, threshold of one, zero release code
		set_regs(8'd0, 8'd1, 8'd0);
		add_word(1, 0, 1, 0, 0, 0);
		add_word(1, 0, 1, 0, 0, 0);
		add_word(1, 1, 1, 0, 0, 0);
		add_word(1, 1, 1, 0, 0, 0);
		add_word(0, 1, 0, 0, 0, 0);
		add_word(1, 1, 1, 0, 0, 0);
		// new edge while still tracking
		add_word(0, 1, 0, 0, 0, 0);
		// clear with the long flag set
		add_word(0, 1, 0, 1, 0, 1);
		add_word(1, 1, 0, 0, 1, 0);
		add_word(1, 1, 1, 0, 0, 0);
		add_word(1, 1, 1, 0, 0, 0);
		add_word(1, 1, 1, 0, 0, 0);
		wait_drained();

		set_regs(8'd3, 8'd5, 8'h5A);
		queue_scan_ticks(350);
		wait_drained();

		set_regs(8'd0, 8'd1, 8'hFF);
		queue_scan_ticks(250);
		wait_drained();

		// zero threshold: long flag only after the count wraps
		set_regs(8'd1, 8'd0, 8'h00);
		queue_scan_ticks(600);
		wait_drained();

		// upper bit of the write data is dropped for the lockout register
		set_regs(8'hFF, 8'd254, 8'h80);
		queue_scan_ticks(150);
		wait_drained();

		set_regs(8'd2, 8'd12, 8'h33);
		@(posedge clk);
		quiet_tail <= 1'b1;
		queue_scan_ticks(250);
		wait_drained();
		repeat (10) @(posedge clk);

		$display("Checked %0d result words across %0d register settings.",
			results_seen, settings_run);
		$display("Long-press flag was up in %0d of them; %0d mismatches.",
			long_words, error_count);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
